// ----- hw/rtl/sfb_pkg.sv -----
// Shared types, constants and the CRC byte function of the stuffed frame builder.
package sfb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW  = 16;
  localparam int unsigned SeqW  = 4;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  localparam logic [ByteW-1:0] FrameHeader   = 8'h55;
  localparam logic [ByteW-1:0] EscapeByte    = 8'h56;
  localparam logic [ByteW-1:0] EscapedEscape = 8'h57;
  localparam logic [ByteW-1:0] FlagMask      = 8'hF0;
  localparam logic [SeqW-1:0]  SeqMax        = 4'hF;
  localparam logic [SeqW-1:0]  SeqFirst      = 4'h1;
  localparam logic [CrcW-1:0]  PolyReset     = 16'h1021;

  typedef enum logic [1:0] {
    REG_BUS_ADDRESS   = 2'd0,
    REG_CONTROL_FLAGS = 2'd1,
    REG_CRC_POLY      = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  // Slot positions of the raw byte sequence of one transaction
  localparam logic [2:0] SlotHeader = 3'd0;
  localparam logic [2:0] SlotAddr   = 3'd1;
  localparam logic [2:0] SlotCtrl   = 3'd2;
  localparam logic [2:0] SlotLen    = 3'd3;
  localparam logic [2:0] SlotBody   = 3'd4;
  localparam logic [2:0] SlotCrcHi  = 3'd5;
  localparam logic [2:0] SlotCrcLo  = 3'd6;

  typedef struct packed {
    logic [ByteW-1:0] bus_address;
    logic [ByteW-1:0] control_flags;
    logic [CrcW-1:0]  crc_poly;
  } cfg_t;

  typedef struct packed {
    logic             is_start;
    logic             with_crc;
    logic [ByteW-1:0] addr;
    logic [ByteW-1:0] ctrl;
    logic [ByteW-1:0] len;
    logic [ByteW-1:0] body;
  } job_t;

  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b,
                                               input logic [CrcW-1:0] poly);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < ByteW; i++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/sfb_regs.sv -----
// APB-style configuration registers of the stuffed frame builder.
module sfb_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfb_pkg::AddrW-1:0] paddr,
  input  logic [sfb_pkg::DataW-1:0] pwdata,
  output logic [sfb_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output sfb_pkg::cfg_t             cfg
);

  sfb_pkg::cfg_t     cfg_r;
  sfb_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = sfb_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bus_address   <= '0;
      cfg_r.control_flags <= '0;
      cfg_r.crc_poly      <= sfb_pkg::PolyReset;
    end else if (wr_en) begin
      unique case (idx)
        sfb_pkg::REG_BUS_ADDRESS:   cfg_r.bus_address   <= pwdata[7:0];
        sfb_pkg::REG_CONTROL_FLAGS: cfg_r.control_flags <= pwdata[7:0];
        sfb_pkg::REG_CRC_POLY:      cfg_r.crc_poly      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sfb_pkg::REG_BUS_ADDRESS:   prdata = {24'h0, cfg_r.bus_address};
      sfb_pkg::REG_CONTROL_FLAGS: prdata = {24'h0, cfg_r.control_flags};
      sfb_pkg::REG_CRC_POLY:      prdata = {16'h0, cfg_r.crc_poly};
      default:                    prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/sfb_ctrl.sv -----
// Frame state tracking: sequence number, remaining data count and job decode.
module sfb_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfb_pkg::cfg_t             cfg,
  input  logic                      accept,
  input  logic                      command,
  input  logic [sfb_pkg::ByteW-1:0] opcode,
  input  logic [sfb_pkg::ByteW-1:0] data_length,
  input  logic [sfb_pkg::ByteW-1:0] data_byte,
  output logic                      push,
  output sfb_pkg::job_t             job,
  output logic [sfb_pkg::SeqW-1:0]  seq
);

  logic [sfb_pkg::SeqW-1:0]  seq_r, seq_nxt;
  logic [sfb_pkg::ByteW-1:0] left_r, left_nxt;
  logic                      in_frame_r, in_frame_nxt;
  logic [sfb_pkg::SeqW-1:0]  seq_step;

  assign seq      = seq_r;
  assign seq_step = (seq_r == sfb_pkg::SeqMax) ? sfb_pkg::SeqFirst : seq_r + 1'b1;

  always_comb begin
    seq_nxt      = seq_r;
    left_nxt     = left_r;
    in_frame_nxt = in_frame_r;
    push         = 1'b0;
    job.is_start = command;
    job.addr     = cfg.bus_address;
    job.ctrl     = (cfg.control_flags & sfb_pkg::FlagMask) | {4'h0, seq_step};
    job.len      = data_length + 1'b1;
    job.body     = command ? opcode : data_byte;
    job.with_crc = command ? (data_length == '0) : (left_r == 8'd1);
    if (accept) begin
      if (command) begin
        push         = 1'b1;
        seq_nxt      = seq_step;
        left_nxt     = data_length;
        in_frame_nxt = (data_length != '0);
      end else if (in_frame_r && left_r != '0) begin
        push         = 1'b1;
        left_nxt     = left_r - 1'b1;
        in_frame_nxt = (left_r != 8'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r      <= '0;
      left_r     <= '0;
      in_frame_r <= 1'b0;
    end else begin
      seq_r      <= seq_nxt;
      left_r     <= left_nxt;
      in_frame_r <= in_frame_nxt;
    end
  end

endmodule

// ----- hw/rtl/sfb_emit.sv -----
// Job register, byte stuffing, CRC accumulation and output register.
module sfb_emit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [sfb_pkg::CrcW-1:0]  crc_poly,
  input  logic                      push,
  input  sfb_pkg::job_t             job,
  output logic                      take,
  output logic                      busy,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sfb_pkg::ByteW-1:0] out_byte,
  output logic                      out_run_last,
  output logic                      out_frame_end
);

  sfb_pkg::job_t             job_r;
  logic                      job_v_r;
  logic [2:0]                slot_r, slot_nxt;
  logic                      phase_r, phase_nxt;
  logic [sfb_pkg::CrcW-1:0]  crc_r, crc_nxt;
  logic                      ov_r;
  logic [sfb_pkg::ByteW-1:0] ob_r;
  logic                      olast_r, oend_r;

  logic                      adv, stuff, last;
  logic [2:0]                last_slot;
  logic [sfb_pkg::ByteW-1:0] raw, wire_b;

  always_comb begin
    unique case (slot_r)
      sfb_pkg::SlotHeader: raw = sfb_pkg::FrameHeader;
      sfb_pkg::SlotAddr:   raw = job_r.addr;
      sfb_pkg::SlotCtrl:   raw = job_r.ctrl;
      sfb_pkg::SlotLen:    raw = job_r.len;
      sfb_pkg::SlotBody:   raw = job_r.body;
      sfb_pkg::SlotCrcHi:  raw = crc_r[15:8];
      sfb_pkg::SlotCrcLo:  raw = crc_r[7:0];
      default:             raw = crc_r[7:0];
    endcase
  end

  assign stuff     = (slot_r != sfb_pkg::SlotHeader) &&
                     (raw == sfb_pkg::FrameHeader || raw == sfb_pkg::EscapeByte);
  assign last_slot = job_r.with_crc ? sfb_pkg::SlotCrcLo : sfb_pkg::SlotBody;
  assign last      = (slot_r == last_slot) && (phase_r || !stuff);
  assign adv       = job_v_r && (!ov_r || out_ready);
  assign take      = !job_v_r || (adv && last);
  assign busy      = job_v_r;

  always_comb begin
    if (!phase_r) begin
      wire_b = stuff ? sfb_pkg::EscapeByte : raw;
    end else begin
      wire_b = (raw == sfb_pkg::FrameHeader) ? sfb_pkg::EscapeByte : sfb_pkg::EscapedEscape;
    end
  end

  always_comb begin
    slot_nxt  = slot_r;
    phase_nxt = phase_r;
    crc_nxt   = crc_r;
    if (adv && !phase_r) begin
      priority if (slot_r == sfb_pkg::SlotHeader) begin
        crc_nxt = '0;
      end else if (slot_r <= sfb_pkg::SlotBody) begin
        crc_nxt = sfb_pkg::crc_byte(crc_r, raw, crc_poly);
      end else begin
        crc_nxt = crc_r;
      end
    end
    if (push) begin
      slot_nxt  = job.is_start ? sfb_pkg::SlotHeader : sfb_pkg::SlotBody;
      phase_nxt = 1'b0;
    end else if (adv && !last) begin
      if (stuff && !phase_r) begin
        phase_nxt = 1'b1;
      end else begin
        slot_nxt  = slot_r + 1'b1;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      ov_r    <= 1'b0;
      slot_r  <= '0;
      phase_r <= 1'b0;
      crc_r   <= '0;
    end else begin
      slot_r  <= slot_nxt;
      phase_r <= phase_nxt;
      crc_r   <= crc_nxt;
      if (push) begin
        job_v_r <= 1'b1;
      end else if (adv && last) begin
        job_v_r <= 1'b0;
      end
      if (adv) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job_r <= job;
    end
    if (adv) begin
      ob_r    <= wire_b;
      olast_r <= last;
      oend_r  <= last && job_r.with_crc;
    end
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_run_last  = olast_r;
  assign out_frame_end = oend_r;

endmodule

// ----- hw/rtl/stuffed_frame_builder_crc16.sv -----
// Top level of the byte-stuffed serial frame builder with CRC16.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    command, opcode, data_length, data_byte
//   out_     output     out_valid/out_ready  out_byte, run_last, frame_end
//   config   APB write  psel/penable/pwrite  bus_address, control_flags, crc_poly
//
// One wire byte leaves per cycle while out_ready is high and a job is pending; a data
// transaction outside a frame is taken with no output.
// The output register is the pacing unit; the job register takes the next transaction
// in the cycle its predecessor's last byte moves into the output register.
// Reset is synchronous; it clears frame state, the job and the output register.
// Stalls on out_ready hold the output register and the job in place.
module stuffed_frame_builder_crc16 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_command,
  input  logic [sfb_pkg::ByteW-1:0] in_opcode,
  input  logic [sfb_pkg::ByteW-1:0] in_data_length,
  input  logic [sfb_pkg::ByteW-1:0] in_data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [sfb_pkg::ByteW-1:0] out_byte,
  output logic                      out_run_last,
  output logic                      out_frame_end,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [sfb_pkg::AddrW-1:0] paddr,
  input  logic [sfb_pkg::DataW-1:0] pwdata,
  output logic [sfb_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  sfb_pkg::cfg_t            cfg;
  sfb_pkg::job_t            job;
  logic                     push, take, busy, accept;
  logic [sfb_pkg::SeqW-1:0] seq;

  assign in_ready = take;
  assign accept   = in_valid && take;

  sfb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .accept      (accept),
    .command     (in_command),
    .opcode      (in_opcode),
    .data_length (in_data_length),
    .data_byte   (in_data_byte),
    .push        (push),
    .job         (job),
    .seq         (seq)
  );

  sfb_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .crc_poly      (cfg.crc_poly),
    .push          (push),
    .job           (job),
    .take          (take),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_run_last)
    else $error("frame end without run last");

  a_seq_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command |=> seq != '0)
    else $error("sequence number zero after start");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && busy |-> !in_ready)
    else $error("input taken while output stalled with pending job");

endmodule

// ----- test/stuffed_frame_builder_crc16_tb.sv -----
// Self-checking testbench of the stuffed frame builder: random frames, stuffing and CRC check.
module stuffed_frame_builder_crc16_tb;

  typedef logic [sfb_pkg::ByteW-1:0] byte_t;
  typedef logic [sfb_pkg::CrcW-1:0]  crc_t;
  typedef logic [sfb_pkg::DataW-1:0] data_t;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_START = 1'b1;
  localparam int   SettleCycles = 32;
  localparam int   HoldCycles   = 400;
  localparam int   StallLimit   = 5000;

  typedef struct packed {
    logic  cmd;
    byte_t opcode;
    byte_t dlen;
    byte_t dbyte;
  } frame_item_t;

  typedef struct packed {
    byte_t b;
    logic  last;
    logic  fend;
  } wire_byte_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_command = CMD_DATA;
  byte_t                     in_opcode = '0;
  byte_t                     in_data_length = '0;
  byte_t                     in_data_byte = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  byte_t                     out_byte;
  logic                      out_run_last;
  logic                      out_frame_end;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [sfb_pkg::AddrW-1:0] paddr = '0;
  data_t                     pwdata = '0;
  data_t                     prdata;
  logic                      pready;

  stuffed_frame_builder_crc16 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_opcode      (in_opcode),
    .in_data_length (in_data_length),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Frame state and register copies
  byte_t                    cfg_addr  = '0;
  byte_t                    cfg_flags = '0;
  crc_t                     cfg_poly  = sfb_pkg::PolyReset;
  logic [sfb_pkg::SeqW-1:0] frm_seq   = '0;
  crc_t                     frm_crc   = '0;
  byte_t                    frm_left  = '0;
  logic                     frm_open  = 1'b0;

  frame_item_t item_q[$];
  wire_byte_t  wire_expect_q[$];
  byte_t       line_q[$];

  frame_item_t drv_item;
  wire_byte_t  got_byte;
  wire_byte_t  want_byte;
  logic        in_taken = 1'b0;
  int          in_idle_pct = 0;
  int          out_idle_pct = 0;
  int          hold_req_cnt = 0;
  int          hold_ack_cnt = 0;
  int          hold_cnt = 0;
  int          stall_cnt = 0;
  int          n_errors = 0;

  function automatic crc_t crc16_step(input crc_t crc, input byte_t b, input crc_t poly);
    crc_t c;
    logic fb;
    c = crc;
    for (int i = sfb_pkg::ByteW - 1; i >= 0; i--) begin
      fb = c[sfb_pkg::CrcW-1] ^ b[i];
      c = {c[sfb_pkg::CrcW-2:0], 1'b0} ^ (fb ? poly : '0);
    end
    return c;
  endfunction

  task automatic stuff_byte(input byte_t b);
    if (b == sfb_pkg::FrameHeader) begin
      line_q.push_back(sfb_pkg::EscapeByte);
      line_q.push_back(sfb_pkg::EscapeByte);
    end else if (b == sfb_pkg::EscapeByte) begin
      line_q.push_back(sfb_pkg::EscapeByte);
      line_q.push_back(sfb_pkg::EscapedEscape);
    end else begin
      line_q.push_back(b);
    end
  endtask

  task automatic body_byte(input byte_t b);
    frm_crc = crc16_step(frm_crc, b, cfg_poly);
    stuff_byte(b);
  endtask

  task automatic wire_bytes_for(input frame_item_t it);
    logic       done;
    wire_byte_t wb;
    line_q.delete();
    done = 1'b0;
    if (it.cmd == CMD_START) begin
      frm_seq = (frm_seq == sfb_pkg::SeqMax) ? sfb_pkg::SeqFirst : frm_seq + 1'b1;
      frm_crc = '0;
      line_q.push_back(sfb_pkg::FrameHeader);
      body_byte(cfg_addr);
      body_byte((cfg_flags & sfb_pkg::FlagMask) | {4'h0, frm_seq});
      body_byte(it.dlen + 8'd1);
      body_byte(it.opcode);
      frm_left = it.dlen;
      frm_open = (it.dlen != 0);
      done = (it.dlen == 0);
    end else if (frm_open && frm_left != 0) begin
      body_byte(it.dbyte);
      frm_left = frm_left - 1'b1;
      if (frm_left == 0) begin
        frm_open = 1'b0;
        done = 1'b1;
      end
    end
    if (done) begin
      stuff_byte(frm_crc[sfb_pkg::CrcW-1:sfb_pkg::ByteW]);
      stuff_byte(frm_crc[sfb_pkg::ByteW-1:0]);
    end
    foreach (line_q[k]) begin
      wb.b = line_q[k];
      wb.last = (k == line_q.size() - 1);
      wb.fend = wb.last && done;
      wire_expect_q.push_back(wb);
    end
  endtask

  // Driver: present the next item, hold it until it is accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (item_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        drv_item = item_q.pop_front();
        in_valid <= 1'b1;
        in_command <= drv_item.cmd;
        in_opcode <= drv_item.opcode;
        in_data_length <= drv_item.dlen;
        in_data_byte <= drv_item.dbyte;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt = hold_req_cnt;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: predict on input transactions, check output transactions
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      wire_bytes_for('{cmd: in_command, opcode: in_opcode, dlen: in_data_length,
                       dbyte: in_data_byte});
    end
    if (rst_n && out_valid && out_ready) begin
      got_byte = '{b: out_byte, last: out_run_last, fend: out_frame_end};
      if (wire_expect_q.size() == 0) begin
        $error("unexpected output byte %02h", out_byte);
        n_errors++;
      end else begin
        want_byte = wire_expect_q.pop_front();
        if (got_byte.b !== want_byte.b) begin
          $error("out_byte expected %02h got %02h", want_byte.b, got_byte.b);
          n_errors++;
        end
        if (got_byte.last !== want_byte.last) begin
          $error("run_last expected %0b got %0b", want_byte.last, got_byte.last);
          n_errors++;
        end
        if (got_byte.fend !== want_byte.fend) begin
          $error("frame_end expected %0b got %0b", want_byte.fend, got_byte.fend);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic reg_write(input sfb_pkg::reg_idx_t idx, input data_t val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    unique case (idx)
      sfb_pkg::REG_BUS_ADDRESS:   cfg_addr = val[sfb_pkg::ByteW-1:0];
      sfb_pkg::REG_CONTROL_FLAGS: cfg_flags = val[sfb_pkg::ByteW-1:0];
      sfb_pkg::REG_CRC_POLY:      cfg_poly = val[sfb_pkg::CrcW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input byte_t a, input byte_t f, input crc_t p);
    reg_write(sfb_pkg::REG_BUS_ADDRESS, data_t'(a));
    reg_write(sfb_pkg::REG_CONTROL_FLAGS, data_t'(f));
    reg_write(sfb_pkg::REG_CRC_POLY, data_t'(p));
  endtask

  task automatic add_start(input byte_t op, input byte_t len);
    item_q.push_back('{cmd: CMD_START, opcode: op, dlen: len,
                       dbyte: byte_t'($urandom_range(255))});
  endtask

  task automatic add_data(input byte_t b);
    item_q.push_back('{cmd: CMD_DATA, opcode: byte_t'($urandom_range(255)),
                       dlen: byte_t'($urandom_range(255)), dbyte: b});
  endtask

  function automatic byte_t pick_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return sfb_pkg::FrameHeader;
    if (r == 1) return sfb_pkg::EscapeByte;
    return byte_t'($urandom_range(255));
  endfunction

  // Mostly complete frames with random content, some abandoned, some stray data
  task automatic gen_traffic(input int n_items);
    int   cnt;
    int   len;
    int   n_send;
    int   r;
    logic open;
    cnt = 0;
    open = 1'b0;
    while (cnt < n_items) begin
      if (!open && $urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 2)) add_data(pick_byte());
      end
      r = $urandom_range(99);
      if (r < 50) len = $urandom_range(3);
      else if (r < 85) len = $urandom_range(4, 12);
      else if (r < 95) len = $urandom_range(13, 24);
      else len = $urandom_range(255);
      if (len > 24) n_send = $urandom_range(6);
      else if (len > 0 && $urandom_range(9) == 0) n_send = $urandom_range(len - 1);
      else n_send = len;
      add_start(pick_byte(), byte_t'(len));
      repeat (n_send) add_data(pick_byte());
      open = (n_send < len);
      cnt += 1 + n_send;
    end
  endtask

  task automatic wait_drained();
    while (item_q.size() > 0 || in_valid || wire_expect_q.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_idle_pct = 8;
    out_idle_pct = 61;

    add_data(8'h33);
    add_start(sfb_pkg::FrameHeader, 8'd0);
    add_start(sfb_pkg::EscapeByte, 8'd2);
    add_data(sfb_pkg::FrameHeader);
    add_data(sfb_pkg::EscapeByte);
    add_start(8'hFF, 8'd1);
    add_data(8'h00);
    add_start(8'h00, 8'd255);
    add_data(8'hFF);
    add_data(8'hAA);
    add_start(8'h12, 8'd3);
    add_data(sfb_pkg::FrameHeader);
    add_data(8'h01);
    add_data(sfb_pkg::EscapeByte);
    add_data(8'h33);
    add_start(8'h5A, 8'd84);
    add_start(8'hA5, 8'd85);
    add_start(8'h80, 8'd0);
    wait_drained();

    set_config(sfb_pkg::FrameHeader, 8'hFF, 16'hFFFF);
    gen_traffic(120);
    hold_req_cnt++;
    wait_drained();

    in_idle_pct = 61;
    out_idle_pct = 8;
    set_config(sfb_pkg::EscapeByte, 8'h50, 16'h0000);
    gen_traffic(120);
    wait_drained();

    in_idle_pct = 0;
    out_idle_pct = 0;
    set_config(8'hFF, 8'h0F, 16'h8005);
    gen_traffic(115);
    wait_drained();

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sfb_pkg.sv
hw/rtl/sfb_regs.sv
hw/rtl/sfb_ctrl.sv
hw/rtl/sfb_emit.sv
hw/rtl/stuffed_frame_builder_crc16.sv
test/stuffed_frame_builder_crc16_tb.sv
